>>> hdl/source_rate_controller_assert.svh
// assertion macros for the source rate controller
`ifndef SOURCE_RATE_CONTROLLER_ASSERT_SVH
`define SOURCE_RATE_CONTROLLER_ASSERT_SVH

// condition and consequence in the same cycle
`define SRCTL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srctl check failed");

// consequence in the cycle after the condition
`define SRCTL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srctl check failed");

`endif

>>> hdl/srctl_pkg.sv
package srctl_pkg;

  localparam int RATE_BITS_DEF = 32;
  localparam int CFG_W         = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int ELAPSED_W     = 40;
  localparam int BACKLOG_W     = 24;
  localparam int BUDGET_W      = 20;
  localparam int SUM_W         = 64;
  localparam int COUNT_W       = 32;
  localparam int OUT_W         = 32;
  localparam int FACTOR_W      = 17;
  localparam int FRAC_W        = 16;
  localparam int THR_SCALE_W   = 16;
  localparam int THR_W         = BUDGET_W + 1 + THR_SCALE_W;
  localparam int THR_SHIFT     = 10;
  localparam int MARGIN_W      = 19;

  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_RATE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_BUDGET = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEST_LENGTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_MODE    = 3'd7;

  localparam logic [CFG_W-1:0]    DEFAULT_RATE_RST = 32'd100000;
  localparam logic [CFG_W-1:0]    MAX_RATE_RST     = 32'd1000000;
  localparam logic [CFG_W-1:0]    WINDOW_RST       = 32'd1000;
  localparam logic [BUDGET_W-1:0] BUDGET_RST       = 20'd1000;
  localparam logic [CFG_W-1:0]    TEST_LENGTH_RST  = 32'd60000;
  localparam logic [CFG_W-1:0]    RAMP_STEP_RST    = 32'd1000;

  localparam logic [THR_SCALE_W-1:0] THR_SCALE        = 16'd20000;
  localparam logic [BACKLOG_W-1:0]   OVERLOAD_BACKLOG = 24'd500000;
  localparam logic [MARGIN_W-1:0]    FIRST_MARGIN     = 19'd1000;
  localparam logic [MARGIN_W-1:0]    ADAPT_MARGIN     = 19'd300000;
  localparam logic [MARGIN_W-1:0]    SAMPLE_MARGIN    = 19'd120000;
  localparam logic [MARGIN_W-1:0]    RAMP_MARGIN      = 19'd10000;

  localparam logic [1:0] FAC_DN2 = 2'd0;
  localparam logic [1:0] FAC_UP2 = 2'd1;
  localparam logic [1:0] FAC_DN1 = 2'd2;
  localparam logic [1:0] FAC_UP1 = 2'd3;

  localparam logic [2:0] PH_NONE  = 3'd0;
  localparam logic [2:0] PH_FIRST = 3'd1;
  localparam logic [2:0] PH_ADAPT = 3'd2;
  localparam logic [2:0] PH_RHOLD = 3'd3;
  localparam logic [2:0] PH_RSTEP = 3'd4;

  typedef struct packed {
    logic capture;
    logic eval;
    logic mul_hi;
    logic mul_lo;
    logic update;
    logic accum;
    logic div_start;
    logic load;
  } ctl_cmd_t;

  typedef struct packed {
    logic done;
    logic div_done;
  } dp_status_t;

  // q1.16 scale factors, truncated
  function automatic logic [FACTOR_W-1:0] factor_value(input logic [1:0] code);
    logic [FACTOR_W-1:0] f;
    unique case (code)
      FAC_DN2: f = 17'd64225;
      FAC_UP2: f = 17'd66846;
      FAC_DN1: f = 17'd64880;
      FAC_UP1: f = 17'd66191;
      default: f = 17'd64225;
    endcase
    return f;
  endfunction

endpackage

>>> hdl/srctl_div.sv
module srctl_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [srctl_pkg::SUM_W-1:0]   dividend,
  input  logic [srctl_pkg::COUNT_W-1:0] divisor,
  output logic                          done,
  output logic [srctl_pkg::SUM_W-1:0]   quotient
);
  import srctl_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SUM_W - 1);

  logic               running;
  logic [CNT_W-1:0]   count;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] dvs;
  logic [COUNT_W:0]   rem_shift;
  logic [COUNT_W:0]   rem_sub;

  assign rem_shift = {rem, quotient[SUM_W-1]};
  assign rem_sub   = rem_shift - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && count == CNT_LAST) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  // restoring divide, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      count    <= '0;
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (running) begin
      count <= count + CNT_W'(1);
      if (!rem_sub[COUNT_W]) begin
        rem      <= rem_sub[COUNT_W-1:0];
        quotient <= {quotient[SUM_W-2:0], 1'b1};
      end else begin
        rem      <= rem_shift[COUNT_W-1:0];
        quotient <= {quotient[SUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> hdl/srctl_dp.sv
module srctl_dp #(
  parameter int RATE_BITS = srctl_pkg::RATE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [srctl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srctl_pkg::CFG_W-1:0]     cfg_data,
  input  logic [srctl_pkg::ELAPSED_W-1:0] elapsed_ms,
  input  logic [srctl_pkg::BACKLOG_W-1:0] backlog,
  input  logic                            source_offline,
  input  srctl_pkg::ctl_cmd_t             cmd,
  output srctl_pkg::dp_status_t           status,
  output logic [srctl_pkg::OUT_W-1:0]     new_rate,
  output logic                            finished,
  output logic [srctl_pkg::OUT_W-1:0]     average_rate
);
  import srctl_pkg::*;

  localparam int SW    = RATE_BITS + FACTOR_W + 1;
  localparam int MW    = RATE_BITS + FACTOR_W;
  localparam int LO_W  = FRAC_W + FACTOR_W;
  localparam int EW    = ELAPSED_W + 1;
  localparam logic [RATE_BITS-1:0] RATE_MAX = '1;

  function automatic logic [RATE_BITS-1:0] sat_rate(input logic [SW-1:0] v);
    return (v > SW'(RATE_MAX)) ? RATE_MAX : v[RATE_BITS-1:0];
  endfunction

  // configuration
  logic [CFG_W-1:0]    default_rate;
  logic [CFG_W-1:0]    max_rate;
  logic [CFG_W-1:0]    window_ms;
  logic [BUDGET_W-1:0] delay_budget_ms;
  logic [CFG_W-1:0]    test_length_ms;
  logic [CFG_W-1:0]    ramp_step;
  logic                ramp_test_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_rate    <= DEFAULT_RATE_RST;
      max_rate        <= MAX_RATE_RST;
      window_ms       <= WINDOW_RST;
      delay_budget_ms <= BUDGET_RST;
      test_length_ms  <= TEST_LENGTH_RST;
      ramp_step       <= RAMP_STEP_RST;
      ramp_test_mode  <= 1'b0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_INITIAL_RATE: ;
        REG_DEFAULT_RATE: default_rate    <= cfg_data;
        REG_MAX_RATE:     max_rate        <= cfg_data;
        REG_WINDOW:       window_ms       <= cfg_data;
        REG_DELAY_BUDGET: delay_budget_ms <= cfg_data[BUDGET_W-1:0];
        REG_TEST_LENGTH:  test_length_ms  <= cfg_data;
        REG_RAMP_STEP:    ramp_step       <= cfg_data;
        REG_RAMP_MODE:    ramp_test_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // request capture
  logic [ELAPSED_W-1:0] el;
  logic [BACKLOG_W-1:0] bl;
  logic                 off;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      el  <= elapsed_ms;
      bl  <= backlog;
      off <= source_offline;
    end
  end

  // evaluation: exit, flags, phase, factor
  logic             done, raise_flag, lower_flag, overload_seen, acc_en;
  logic [2:0]       phase;
  logic [1:0]       fac;
  logic             done_next, raise_next, lower_next, overload_next, acc_next;
  logic [2:0]       phase_next;
  logic [1:0]       fac_next;
  logic [EW-1:0]    el_x, win_first, win_adapt, win_sample, win_ramp;
  logic [THR_W-1:0] thr_low, thr_high, bl_x;

  assign el_x       = {1'b0, el};
  assign win_first  = EW'(window_ms) + EW'(FIRST_MARGIN);
  assign win_adapt  = EW'(window_ms) + EW'(ADAPT_MARGIN);
  assign win_sample = EW'(window_ms) + EW'(SAMPLE_MARGIN);
  assign win_ramp   = EW'(window_ms) + EW'(RAMP_MARGIN);
  assign thr_low    = (THR_W'(delay_budget_ms >> 1) * THR_W'(THR_SCALE)) >> THR_SHIFT;
  assign thr_high   = (THR_W'({delay_budget_ms, 1'b0}) * THR_W'(THR_SCALE)) >> THR_SHIFT;
  assign bl_x       = THR_W'(bl);

  always_comb begin
    done_next     = done || (el > ELAPSED_W'(test_length_ms)) || off || overload_seen;
    raise_next    = raise_flag;
    lower_next    = lower_flag;
    overload_next = overload_seen;
    phase_next    = PH_NONE;
    acc_next      = 1'b0;
    if (!done_next) begin
      if (bl_x < thr_low) begin
        raise_next = 1'b1;
        lower_next = 1'b0;
      end else if (bl_x > thr_high) begin
        raise_next = 1'b0;
        lower_next = 1'b1;
      end
      if (el_x <= win_first) begin
        phase_next = PH_FIRST;
      end else if (!ramp_test_mode) begin
        if (el_x > win_adapt) begin
          phase_next = PH_ADAPT;
          acc_next   = (el_x >= win_sample);
        end
      end else if (el_x <= win_ramp) begin
        phase_next = PH_RHOLD;
      end else if (bl > OVERLOAD_BACKLOG) begin
        overload_next = 1'b1;
      end else begin
        phase_next = PH_RSTEP;
      end
    end
    if (phase_next == PH_FIRST) begin
      fac_next = lower_next ? FAC_DN2 : FAC_UP2;
    end else begin
      fac_next = lower_next ? FAC_DN1 : FAC_UP1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done          <= 1'b0;
      raise_flag    <= 1'b0;
      lower_flag    <= 1'b0;
      overload_seen <= 1'b0;
      phase         <= PH_NONE;
      acc_en        <= 1'b0;
      fac           <= FAC_DN2;
    end else if (cmd.eval) begin
      done          <= done_next;
      raise_flag    <= raise_next;
      lower_flag    <= lower_next;
      overload_seen <= overload_next;
      phase         <= phase_next;
      acc_en        <= acc_next;
      fac           <= fac_next;
    end
  end

  // shared multiplier: high part, then low part of the rate
  logic [RATE_BITS-1:0]  rate;
  logic [RATE_BITS+FRAC_W-1:0] rate_ext;
  logic [RATE_BITS-1:0]  mul_a;
  logic [MW-1:0]         mul_res;
  logic [MW-1:0]         prod_hi;
  logic [LO_W-1:0]       prod_lo;

  assign rate_ext = {{FRAC_W{1'b0}}, rate};
  assign mul_a    = cmd.mul_hi ? rate_ext[RATE_BITS+FRAC_W-1:FRAC_W]
                               : RATE_BITS'(rate[FRAC_W-1:0]);
  assign mul_res  = MW'(mul_a) * MW'(factor_value(fac));

  always_ff @(posedge clk) begin
    if (cmd.mul_hi) prod_hi <= mul_res;
    if (cmd.mul_lo) prod_lo <= mul_res[LO_W-1:0];
  end

  // rate update
  logic [SW-1:0] scale, dec_v, inc_v, rate_x, def_x, half_x, max_x, fill_v, rate_next;

  assign scale  = SW'(prod_hi) + SW'(prod_lo[LO_W-1:FRAC_W]);
  assign dec_v  = (scale == '0) ? '0 : scale - SW'(1);
  assign inc_v  = scale + SW'(1);
  assign rate_x = SW'(rate);
  assign def_x  = SW'(default_rate);
  assign half_x = SW'(default_rate >> 1);
  assign max_x  = SW'(max_rate);

  always_comb begin
    fill_v    = (rate_x > half_x) ? inc_v : ((ramp_test_mode ? half_x : def_x) + SW'(1));
    rate_next = rate_x;
    unique case (phase)
      PH_FIRST: begin
        if (lower_flag)      rate_next = dec_v;
        else if (raise_flag) rate_next = (fill_v > def_x) ? def_x : fill_v;
      end
      PH_ADAPT: begin
        if (lower_flag)      rate_next = dec_v;
        else if (raise_flag) rate_next = (inc_v > max_x) ? max_x : inc_v;
      end
      PH_RHOLD: rate_next = def_x;
      PH_RSTEP: rate_next = rate_x + SW'(ramp_step);
      default:  rate_next = rate_x;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= '0;
    end else if (cfg_write_en && cfg_index == REG_INITIAL_RATE) begin
      rate <= sat_rate(SW'(cfg_data));
    end else if (cmd.update) begin
      rate <= sat_rate(rate_next);
    end
  end

  // running average statistics
  logic [SUM_W-1:0]   rate_sum;
  logic [COUNT_W-1:0] sample_count;
  logic [SUM_W:0]     sum_add;

  assign sum_add = {1'b0, rate_sum} + (SUM_W+1)'(rate);

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_sum     <= '0;
      sample_count <= '0;
    end else if (cmd.accum && acc_en && sample_count != '1) begin
      rate_sum     <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      sample_count <= sample_count + COUNT_W'(1);
    end
  end

  logic               div_done;
  logic [SUM_W-1:0]   quotient;
  logic [COUNT_W-1:0] divisor;

  assign divisor = (sample_count == '0) ? COUNT_W'(1) : sample_count;

  srctl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (rate_sum),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  assign status.done     = done;
  assign status.div_done = div_done;

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      new_rate <= (rate_x > SW'({OUT_W{1'b1}})) ? '1 : rate_x[OUT_W-1:0];
      finished <= done;
      if (!done) begin
        average_rate <= '0;
      end else if (quotient[SUM_W-1:OUT_W] != '0) begin
        average_rate <= '1;
      end else begin
        average_rate <= quotient[OUT_W-1:0];
      end
    end
  end

endmodule

>>> hdl/srctl_ctrl.sv
module srctl_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   tick_valid,
  output logic                   tick_stall,
  output logic                   result_valid,
  input  logic                   result_stall,
  input  srctl_pkg::dp_status_t  status,
  output srctl_pkg::ctl_cmd_t    cmd
);
  import srctl_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EVAL   = 4'd1;
  localparam logic [3:0] S_MHI    = 4'd2;
  localparam logic [3:0] S_MLO    = 4'd3;
  localparam logic [3:0] S_UPD    = 4'd4;
  localparam logic [3:0] S_ACC    = 4'd5;
  localparam logic [3:0] S_DSTART = 4'd6;
  localparam logic [3:0] S_DWAIT  = 4'd7;
  localparam logic [3:0] S_LOAD   = 4'd8;

  logic [3:0] state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (tick_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_MHI;
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        state_next = status.done ? S_DSTART : S_MLO;
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.accum  = 1'b1;
        state_next = S_LOAD;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DWAIT;
      end
      S_DWAIT: begin
        if (status.div_done) state_next = S_LOAD;
      end
      S_LOAD: begin
        if (!result_valid || !result_stall) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign tick_stall = (state != S_IDLE);

endmodule

>>> hdl/source_rate_controller.sv
// steps while the test runs: capture, evaluate, multiply high, multiply low,
// update, accumulate, load; once the test has ended: capture, evaluate,
// multiply high, serial average divide, load. One tick in flight at a time.
// a finished result may wait in the output register while the next tick runs
// reset: synchronous, active high; registers return to defaults, rate and stats clear
`include "source_rate_controller_assert.svh"

module source_rate_controller #(
  parameter int RATE_BITS = srctl_pkg::RATE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [srctl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srctl_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            tick_valid,
  output logic                            tick_stall,
  input  logic [srctl_pkg::ELAPSED_W-1:0] elapsed_ms,
  input  logic [srctl_pkg::BACKLOG_W-1:0] backlog,
  input  logic                            source_offline,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [srctl_pkg::OUT_W-1:0]     new_rate,
  output logic                            finished,
  output logic [srctl_pkg::OUT_W-1:0]     average_rate
);
  import srctl_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  srctl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  srctl_dp #(
    .RATE_BITS (RATE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .elapsed_ms     (elapsed_ms),
    .backlog        (backlog),
    .source_offline (source_offline),
    .cmd            (cmd),
    .status         (status),
    .new_rate       (new_rate),
    .finished       (finished),
    .average_rate   (average_rate)
  );

  `SRCTL_ASSERT_NEXT(a_busy_after_request, tick_valid && !tick_stall, tick_stall)
  `SRCTL_ASSERT_SAME(a_load_no_overwrite, cmd.load, !result_valid || !result_stall)
  `SRCTL_ASSERT_SAME(a_divide_only_done, cmd.div_start, status.done)
  `SRCTL_ASSERT_SAME(a_average_zero_running, result_valid && !finished, average_rate == '0)

endmodule
